/* hdl/miq_pkg.sv */
// Shared constants for the menu input qualifier: event codes, register
// indexes, reset values and field widths. No dependencies.
package miq_pkg;

  localparam int SampleBitsDefault = 12;

  localparam int EventBits = 3;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits = 16;
  localparam int CenterBits = 12;
  localparam int CountBits = 11;
  localparam int DebounceBits = 16;
  localparam int TimeBits = 32;

  localparam logic [EventBits-1:0] EV_NONE   = 3'd0;
  localparam logic [EventBits-1:0] EV_UP     = 3'd1;
  localparam logic [EventBits-1:0] EV_DOWN   = 3'd2;
  localparam logic [EventBits-1:0] EV_SELECT = 3'd3;
  localparam logic [EventBits-1:0] EV_BACK   = 3'd4;

  localparam logic [CfgIndexBits-1:0] REG_ENABLED  = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_CENTER   = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_DEADZONE = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_TRIGGER  = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE = 3'd4;

  localparam logic [CenterBits-1:0]   CenterDefault = 12'd2048;
  localparam logic [CountBits-1:0]    DeadzoneReset = 11'd102;
  localparam logic [CountBits-1:0]    TriggerReset  = 11'd1024;
  localparam logic [DebounceBits-1:0] DebounceReset = 16'd20;

endpackage

/* hdl/menu_input_qualifier_core.sv */
// Menu input qualifier: debounces two buttons and applies hysteresis to one
// joystick axis, giving one menu event per poll. Depends on miq_pkg.
//
// Usage:
//   Polls arrive on the s_axis channel; tdata holds, from bit 0 up,
//   select_level, back_level, joy_sample (SAMPLE_BITS) and now_ms (32 bits),
//   zero-padded to whole bytes. Buttons are active low.
//   Each accepted poll yields exactly one event on m_axis, tdata[2:0] =
//   menu_event (0 none, 1 up, 2 down, 3 select, 4 back).
//   The event appears in the output register on the cycle after the
//   request is accepted. Throughput is one poll per cycle while the
//   receiver takes events; the button and tilt state update in the same
//   cycle the poll is taken. When the receiver stalls, the event holds in
//   the output register and s_axis_tready drops until it is taken; a new
//   poll is taken in the same cycle the held event leaves.
//   The cfg channel writes registers by index (0 enabled, 1 adc_center,
//   2 deadzone_counts, 3 trigger_counts, 4 debounce_ms); it is always ready
//   and should be used only while the block is idle.
//   Reset (rst, synchronous) disables the block, loads the default register
//   values, clears all button and tilt state and empties the output.
module menu_input_qualifier_core #(
  parameter int SAMPLE_BITS = miq_pkg::SampleBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // select_level, back_level, joy_sample, now_ms; zero-padded to bytes.
  input  logic [((2 + SAMPLE_BITS + miq_pkg::TimeBits + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // menu_event in bits 2:0, upper bits zero.
  output logic [7:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [miq_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [miq_pkg::CfgDataBits-1:0]  cfg_data
);
  import miq_pkg::*;

  localparam int JoyLsb = 2;
  localparam int TimeLsb = JoyLsb + SAMPLE_BITS;
  // Signed compare width that holds the offset and the negated thresholds.
  localparam int CmpBits = ((SAMPLE_BITS > CountBits) ? SAMPLE_BITS : CountBits) + 2;

  localparam logic [1:0] TILT_CENTER = 2'd0;
  localparam logic [1:0] TILT_UP     = 2'd1;
  localparam logic [1:0] TILT_DOWN   = 2'd2;

  // Configuration registers.
  logic                    enabled;
  logic [SAMPLE_BITS-1:0]  adc_center;
  logic [CountBits-1:0]    deadzone_counts;
  logic [CountBits-1:0]    trigger_counts;
  logic [DebounceBits-1:0] debounce_ms;

  // Qualifier state.
  logic                select_down, select_done;
  logic [TimeBits-1:0] select_since;
  logic                back_down, back_done;
  logic [TimeBits-1:0] back_since;
  logic [1:0]          tilt_state;

  logic                select_down_next, select_done_next;
  logic [TimeBits-1:0] select_since_next;
  logic                back_down_next, back_done_next;
  logic [TimeBits-1:0] back_since_next;
  logic [1:0]          tilt_state_next;

  logic                out_valid;
  logic [EventBits-1:0] out_event;
  logic [EventBits-1:0] event_next;

  logic                   s_accept;
  logic                   sel_low, back_low;
  logic [SAMPLE_BITS-1:0] joy;
  logic [TimeBits-1:0]    now;
  logic [TimeBits-1:0]    sel_held, back_held;
  logic signed [CmpBits-1:0] off, dz, tr;
  logic                   centered;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {{(8 - EventBits){1'b0}}, out_event};

  assign sel_low  = !s_axis_tdata[0];
  assign back_low = !s_axis_tdata[1];
  assign joy = s_axis_tdata[JoyLsb +: SAMPLE_BITS];
  assign now = s_axis_tdata[TimeLsb +: TimeBits];

  assign sel_held  = now - select_since;
  assign back_held = now - back_since;

  assign off = CmpBits'(signed'({1'b0, joy})) - CmpBits'(signed'({1'b0, adc_center}));
  assign dz = signed'(CmpBits'(deadzone_counts));
  assign tr = signed'(CmpBits'(trigger_counts));
  assign centered = (off <= dz) && (off >= -dz);

  always_comb begin
    select_down_next  = select_down;
    select_done_next  = select_done;
    select_since_next = select_since;
    back_down_next    = back_down;
    back_done_next    = back_done;
    back_since_next   = back_since;
    tilt_state_next   = tilt_state;
    event_next        = EV_NONE;

    if (enabled) begin
      // Select stage.
      if (sel_low && !select_down) begin
        select_down_next  = 1'b1;
        select_since_next = now;
        select_done_next  = 1'b0;
      end else if (!sel_low) begin
        select_down_next = 1'b0;
        select_done_next = 1'b0;
      end else if (!select_done && (sel_held >= TimeBits'(debounce_ms))) begin
        select_done_next = 1'b1;
        event_next = EV_SELECT;
      end

      // Back stage runs only when select did not fire.
      if (event_next == EV_NONE) begin
        if (back_low && !back_down) begin
          back_down_next  = 1'b1;
          back_since_next = now;
          back_done_next  = 1'b0;
        end else if (!back_low) begin
          back_down_next = 1'b0;
          back_done_next = 1'b0;
        end else if (!back_done && (back_held >= TimeBits'(debounce_ms))) begin
          back_done_next = 1'b1;
          event_next = EV_BACK;
        end
      end

      // Joystick hysteresis runs only when neither button fired.
      if (event_next == EV_NONE) begin
        case (tilt_state)
          TILT_UP: begin
            if (off <= dz) tilt_state_next = TILT_CENTER;
          end
          TILT_DOWN: begin
            if (off >= -dz) tilt_state_next = TILT_CENTER;
          end
          default: begin
            tilt_state_next = TILT_CENTER;
            if (!centered && (off > tr)) begin
              tilt_state_next = TILT_UP;
              event_next = EV_UP;
            end else if (!centered && (off < -tr)) begin
              tilt_state_next = TILT_DOWN;
              event_next = EV_DOWN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      adc_center      <= SAMPLE_BITS'(CenterDefault);
      deadzone_counts <= DeadzoneReset;
      trigger_counts  <= TriggerReset;
      debounce_ms     <= DebounceReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:  enabled         <= cfg_data[0];
        REG_CENTER:   adc_center      <= SAMPLE_BITS'(cfg_data[CenterBits-1:0]);
        REG_DEADZONE: deadzone_counts <= cfg_data[CountBits-1:0];
        REG_TRIGGER:  trigger_counts  <= cfg_data[CountBits-1:0];
        REG_DEBOUNCE: debounce_ms     <= cfg_data[DebounceBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_down  <= 1'b0;
      select_done  <= 1'b0;
      select_since <= '0;
      back_down    <= 1'b0;
      back_done    <= 1'b0;
      back_since   <= '0;
      tilt_state   <= TILT_CENTER;
      out_valid    <= 1'b0;
    end else begin
      if (s_accept) begin
        select_down  <= select_down_next;
        select_done  <= select_done_next;
        select_since <= select_since_next;
        back_down    <= back_down_next;
        back_done    <= back_done_next;
        back_since   <= back_since_next;
        tilt_state   <= tilt_state_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) out_event <= event_next;
  end

  // A button can only have fired while it is still held.
  assert property (@(posedge clk) disable iff (rst) select_done |-> select_down)
    else $error("select_done set without select_down");
  assert property (@(posedge clk) disable iff (rst) back_done |-> back_down)
    else $error("back_done set without back_down");
  // The unused tilt code is never entered.
  assert property (@(posedge clk) disable iff (rst) tilt_state != 2'd3)
    else $error("tilt_state reached unused code");
  // A disabled block answers every poll with no event.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && !enabled |=> out_valid && (out_event == EV_NONE))
    else $error("event produced while disabled");
  // A poll that fires a button leaves the tilt state untouched.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && ((event_next == EV_SELECT) || (event_next == EV_BACK))
    |=> tilt_state == $past(tilt_state))
    else $error("tilt state changed on a button event");

endmodule

/* bench/menu_event_checker.sv */
// Scoreboard for the menu input qualifier: watches the poll, event and
// register channels, predicts one menu event per poll and compares in order.
// Depends on miq_pkg for event codes, register indexes and reset values.
`timescale 1ns / 1ps

module menu_event_checker #(
  parameter int SampleBits = miq_pkg::SampleBitsDefault,
  parameter int PollBits = ((2 + SampleBits + miq_pkg::TimeBits + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              poll_valid,
  input  logic                              poll_ready,
  // select_level, back_level, joy_sample, now_ms; zero-padded to bytes.
  input  logic [PollBits-1:0]               poll_data,
  input  logic                              event_valid,
  input  logic                              event_ready,
  // menu_event in bits 2:0, upper bits zero.
  input  logic [7:0]                        event_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [miq_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [miq_pkg::CfgDataBits-1:0]   cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import miq_pkg::*;

  localparam logic [SampleBits-1:0] CenterReset = SampleBits'(CenterDefault);
  localparam int BtnSelect = 0;
  localparam int BtnBack = 1;
  localparam int MaxPrinted = 100;

  typedef enum logic [1:0] {
    TILT_CENTERED  = 2'd0,
    TILT_UP_HELD   = 2'd1,
    TILT_DOWN_HELD = 2'd2
  } tilt_e;

  logic                    enabled_q;
  logic [SampleBits-1:0]   center_q;
  logic [CountBits-1:0]    deadzone_q;
  logic [CountBits-1:0]    trigger_q;
  logic [DebounceBits-1:0] debounce_q;

  logic                    btn_down [2];
  logic [TimeBits-1:0]     btn_since [2];
  logic                    btn_done [2];
  tilt_e                   tilt_q;

  logic [EventBits-1:0]    expected_events [$];
  logic [EventBits-1:0]    want;

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // A button fires once per press, after it has stayed low for the debounce time.
  function automatic logic button_fires(input int b, input logic level,
                                        input logic [TimeBits-1:0] now);
    logic [TimeBits-1:0] held;
    logic fired;
    held = now - btn_since[b];
    fired = 1'b0;
    if (!level && !btn_down[b]) begin
      btn_down[b] = 1'b1;
      btn_since[b] = now;
      btn_done[b] = 1'b0;
    end else if (level) begin
      btn_down[b] = 1'b0;
      btn_done[b] = 1'b0;
    end else if (!btn_done[b] && held >= TimeBits'(debounce_q)) begin
      btn_done[b] = 1'b1;
      fired = 1'b1;
    end
    return fired;
  endfunction

  function automatic logic [EventBits-1:0] tilt_step(input logic [SampleBits-1:0] sample);
    int off;
    int dz;
    int tr;
    logic centered;
    logic [EventBits-1:0] ev;
    off = int'(sample) - int'(center_q);
    dz = int'(deadzone_q);
    tr = int'(trigger_q);
    centered = (off <= dz) && (off >= -dz);
    ev = EV_NONE;
    case (tilt_q)
      TILT_UP_HELD: begin
        if (off <= dz) tilt_q = TILT_CENTERED;
      end
      TILT_DOWN_HELD: begin
        if (off >= -dz) tilt_q = TILT_CENTERED;
      end
      default: begin
        tilt_q = TILT_CENTERED;
        if (!centered && off > tr) begin
          tilt_q = TILT_UP_HELD;
          ev = EV_UP;
        end else if (!centered && off < -tr) begin
          tilt_q = TILT_DOWN_HELD;
          ev = EV_DOWN;
        end
      end
    endcase
    return ev;
  endfunction

  // Select outranks back, back outranks the joystick; a firing stage
  // leaves the stages below it untouched for this poll.
  function automatic logic [EventBits-1:0] qualify_poll(input logic [PollBits-1:0] d);
    logic [TimeBits-1:0] now;
    logic [EventBits-1:0] ev;
    now = d[2+SampleBits +: TimeBits];
    ev = EV_NONE;
    if (enabled_q) begin
      if (button_fires(BtnSelect, d[0], now)) ev = EV_SELECT;
      else if (button_fires(BtnBack, d[1], now)) ev = EV_BACK;
      else ev = tilt_step(d[2 +: SampleBits]);
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      enabled_q = 1'b0;
      center_q = CenterReset;
      deadzone_q = DeadzoneReset;
      trigger_q = TriggerReset;
      debounce_q = DebounceReset;
      for (int b = 0; b < 2; b++) begin
        btn_down[b] = 1'b0;
        btn_since[b] = '0;
        btn_done[b] = 1'b0;
      end
      tilt_q = TILT_CENTERED;
      expected_events.delete();
      fail_count = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED:  enabled_q = cfg_data[0];
          REG_CENTER:   center_q = SampleBits'(cfg_data[CenterBits-1:0]);
          REG_DEADZONE: deadzone_q = cfg_data[CountBits-1:0];
          REG_TRIGGER:  trigger_q = cfg_data[CountBits-1:0];
          REG_DEBOUNCE: debounce_q = cfg_data[DebounceBits-1:0];
          default: ;
        endcase
      end
      if (poll_valid && poll_ready) expected_events.push_back(qualify_poll(poll_data));
      if (event_valid && event_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("menu event %0d arrived with no poll waiting",
                                    event_data[EventBits-1:0]));
        end else begin
          want = expected_events.pop_front();
          if (event_data[EventBits-1:0] !== want)
            report_mismatch($sformatf("menu event %0d, predicted %0d",
                                      event_data[EventBits-1:0], want));
          if (event_data[7:EventBits] !== '0)
            report_mismatch($sformatf("event padding bits are %b", event_data[7:EventBits]));
        end
      end
      outstanding = expected_events.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the menu input qualifier testbench: clock, reset, poll and register
// stimulus, receiver back-pressure and the verdict. Depends on miq_pkg,
// menu_input_qualifier_core and menu_event_checker.
`timescale 1ns / 1ps

module tb_top;
  import miq_pkg::*;

  localparam int SampleBits = SampleBitsDefault;
  localparam int PollBits = ((2 + SampleBits + TimeBits + 7) / 8) * 8;
  localparam int CycleLimit = 200000;
  localparam int SampleMax = (1 << SampleBits) - 1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // select_level, back_level, joy_sample, now_ms; zero-padded to bytes.
  logic [PollBits-1:0]     s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // menu_event in bits 2:0, upper bits zero.
  logic [7:0]              m_axis_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = REG_ENABLED;
  logic [CfgDataBits-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  event hold_kick;

  // Stimulus shaping state: current time, button levels, settings in force.
  logic [TimeBits-1:0]     now_ms = '0;
  logic                    sel_level = 1'b1;
  logic                    back_level = 1'b1;
  logic [SampleBits-1:0]   center_set;
  logic [CountBits-1:0]    deadzone_set;
  logic [CountBits-1:0]    trigger_set;
  logic [DebounceBits-1:0] debounce_set;

  menu_input_qualifier_core #(.SAMPLE_BITS(SampleBits)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  menu_event_checker #(.SampleBits(SampleBits), .PollBits(PollBits)) event_check (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (s_axis_tvalid),
    .poll_ready  (s_axis_tready),
    .poll_data   (s_axis_tdata),
    .event_valid (m_axis_tvalid),
    .event_ready (m_axis_tready),
    .event_data  (m_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // One long receiver hold-off so the output register fills and the
  // poll channel backs up while requests keep coming.
  initial begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_poll(input logic sel, input logic bk,
                           input logic [SampleBits-1:0] joy,
                           input logic [TimeBits-1:0] t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= PollBits'({t, joy, bk, sel});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Junk fills the register bits above each field, which must be ignored.
  task automatic apply_settings(input logic en, input logic [SampleBits-1:0] center,
                                input logic [CountBits-1:0] dz,
                                input logic [CountBits-1:0] tr,
                                input logic [DebounceBits-1:0] deb,
                                input logic [CfgDataBits-1:0] junk);
    write_reg(REG_ENABLED, {junk[CfgDataBits-1:1], en});
    write_reg(REG_CENTER, {junk[CfgDataBits-1:SampleBits], center});
    write_reg(REG_DEADZONE, {junk[CfgDataBits-1:CountBits], dz});
    write_reg(REG_TRIGGER, {junk[CfgDataBits-1:CountBits], tr});
    write_reg(REG_DEBOUNCE, deb);
    cfg_valid <= 1'b0;
    center_set = center;
    deadzone_set = dz;
    trigger_set = tr;
    debounce_set = deb;
  endtask

  // Samples cluster around the thresholds in force, with extremes and noise.
  function automatic logic [SampleBits-1:0] pick_sample();
    int off;
    int k;
    int v;
    k = int'($urandom_range(2));
    case ($urandom_range(7))
      0: off = int'(trigger_set) + k - 1;
      1: off = -(int'(trigger_set) + k - 1);
      2: off = int'(deadzone_set) + k - 1;
      3: off = -(int'(deadzone_set) + k - 1);
      4: off = int'($urandom_range(40)) - 20;
      5: off = 9999;
      6: off = -9999;
      default: return SampleBits'($urandom_range(SampleMax));
    endcase
    v = int'(center_set) + off;
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    return SampleBits'(v);
  endfunction

  task automatic random_poll();
    int r;
    logic sel;
    logic bk;
    r = $urandom_range(99);
    if (r < 65) now_ms = now_ms + $urandom_range(12);
    else if (r < 80) now_ms = now_ms + $urandom_range(400, 13);
    else if (r < 92) now_ms = now_ms + debounce_set + $urandom_range(2) - 1;
    else if (r < 96) now_ms = 32'hFFFF_FFF0 + $urandom_range(15);
    else now_ms = $urandom;
    // Presses are held for a few polls; releases dominate so the joystick
    // stage gets its turn.
    if (sel_level ? ($urandom_range(99) < 7) : ($urandom_range(99) < 18))
      sel_level = !sel_level;
    if (back_level ? ($urandom_range(99) < 7) : ($urandom_range(99) < 18))
      back_level = !back_level;
    sel = ($urandom_range(99) < 4) ? 1'($urandom_range(1)) : sel_level;
    bk = ($urandom_range(99) < 4) ? 1'($urandom_range(1)) : back_level;
    send_poll(sel, bk, pick_sample(), now_ms);
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the block is disabled: pressed buttons and full tilt give none.
    send_poll(1'b0, 1'b0, 12'd4095, 32'd0);
    send_poll(1'b1, 1'b0, 12'd0, 32'hFFFF_FFFF);
    drain_events();

    apply_settings(1'b1, 12'd2048, 11'd102, 11'd1024, 16'd20, '0);
    // Select press: fires exactly at the debounce time, once, then release.
    send_poll(1'b0, 1'b1, 12'd2048, 32'd1000);
    send_poll(1'b0, 1'b1, 12'd2048, 32'd1019);
    send_poll(1'b0, 1'b1, 12'd2048, 32'd1020);
    send_poll(1'b0, 1'b1, 12'd2048, 32'd1100);
    send_poll(1'b1, 1'b1, 12'd2048, 32'd1101);
    // Buttons with a tilt: up fires, select blocks back and joystick, back follows.
    send_poll(1'b0, 1'b0, 12'd4095, 32'd2000);
    send_poll(1'b0, 1'b0, 12'd2048, 32'd2030);
    send_poll(1'b0, 1'b0, 12'd2048, 32'd2031);
    send_poll(1'b1, 1'b1, 12'd2048, 32'd2032);
    // Joystick hysteresis: tilt, hold, release edge, opposite tilt, exact trigger.
    send_poll(1'b1, 1'b1, 12'd3073, 32'd2040);
    send_poll(1'b1, 1'b1, 12'd4095, 32'd2041);
    send_poll(1'b1, 1'b1, 12'd2151, 32'd2042);
    send_poll(1'b1, 1'b1, 12'd2150, 32'd2043);
    send_poll(1'b1, 1'b1, 12'd1023, 32'd2044);
    send_poll(1'b1, 1'b1, 12'd0, 32'd2045);
    send_poll(1'b1, 1'b1, 12'd1946, 32'd2046);
    send_poll(1'b1, 1'b1, 12'd3072, 32'd2047);
    // Back held across the timestamp wrap.
    send_poll(1'b1, 1'b0, 12'd2048, 32'hFFFF_FFF8);
    send_poll(1'b1, 1'b0, 12'd2048, 32'h0000_000B);
    send_poll(1'b1, 1'b0, 12'd2048, 32'h0000_000C);
    drain_events();

    // Zero debounce with zero thresholds and the center at the bottom.
    apply_settings(1'b1, 12'd0, 11'd0, 11'd0, 16'd0, '0);
    send_poll(1'b0, 1'b1, 12'd0, 32'd5);
    send_poll(1'b0, 1'b1, 12'd0, 32'd5);
    send_poll(1'b1, 1'b1, 12'd0, 32'd6);
    send_poll(1'b1, 1'b1, 12'd1, 32'd7);
    drain_events();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (seg)
        0: apply_settings(1'b1, 12'd2048, 11'd102, 11'd1024, 16'd20, '0);
        1: apply_settings(1'b1, 12'd0, 11'd0, 11'd0, 16'd0, '0);
        2: apply_settings(1'b1, 12'd4095, 11'd2047, 11'd2047, 16'd65535, '0);
        3: apply_settings(1'b0, 12'($urandom), 11'($urandom_range(300)),
                          11'($urandom_range(1500)), 16'($urandom_range(60)),
                          16'($urandom));
        default: apply_settings(1'b1, 12'($urandom_range(3000, 1000)),
                                11'($urandom_range(300)), 11'($urandom_range(1500)),
                                16'($urandom_range(60)), 16'($urandom));
      endcase
      // The disabled phase only checks that nothing comes out, so keep it short.
      n = (seg == 3) ? 30 : 130;
      for (int i = 0; i < n; i++) begin
        if (seg == 0 && i == 40) -> hold_kick;
        random_poll();
      end
      drain_events();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
